@@ rtl/core/sib_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sib_pkg
// Types and constants shared by the inverse S-box table builder and its
// checker.
// ----------------------------------------------------------------------------
package sib_pkg;

	localparam int MAX_BITS = 8;
	localparam int DEPTH    = 1 << MAX_BITS;
	localparam int CNT_W    = MAX_BITS + 1;
	localparam int CFG_W    = 4;
	localparam int PADDR_W  = 3;
	localparam int PDATA_W  = 32;

	typedef enum logic [1:0] {
		REQ_LOAD    = 2'd0,
		REQ_READ    = 2'd1,
		REQ_RESTART = 2'd2
	} req_kind_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_INCOMPLETE = 2'd1,
		ST_NOT_INV    = 2'd2,
		ST_PAST_END   = 2'd3
	} status_t;

	typedef enum logic [0:0] {
		REG_IN_BITS  = 1'b0,
		REG_OUT_BITS = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [1:0]          req_type;
		logic [MAX_BITS-1:0] entry_value;
		logic [MAX_BITS-1:0] query_index;
	} req_t;

	typedef struct packed {
		logic [MAX_BITS-1:0] inverse_value;
		logic [1:0]          status;
	} rsp_t;

	// Saturate a width register to 1..MAX_BITS and return the table size.
	function automatic logic [CNT_W-1:0] width_to_size(input logic [CFG_W-1:0] raw);
		logic [CNT_W-1:0] one;
		logic [CFG_W-1:0] n;
		one = CNT_W'(1);
		if (raw < CFG_W'(1))
			n = CFG_W'(1);
		else if (raw > CFG_W'(MAX_BITS))
			n = CFG_W'(MAX_BITS);
		else
			n = raw;
		return one << n;
	endfunction

endpackage

@@ rtl/core/sbox_inverse_builder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbox_inverse_builder
// Builds the inverse permutation of an S-box while the forward table loads.
//
// Usage: each request (req_valid/req_ready, payload req) is a load of the
// next forward entry, a read of the inverse at an index, or a restart.
// Every request gives exactly one response on rsp_valid/rsp_ready, in order.
// The table widths in_bits and out_bits are set through the APB port while
// no request is in flight; a restart should follow a width change.
// Path: a taken request passes the memory read stage and then the response
// register. Throughput: one request per cycle unless the receiver stalls;
// the inverse table is a single-port memory with at most one access per
// request and the written flags are flip-flops, so every request finishes
// its state update in the cycle it is taken.
// The response register and the memory read stage form a two-deep queue;
// when the receiver stalls, requests are taken until both are full, then
// req_ready drops until rsp_ready returns.
// Reset clears the written flags, load count, not-invertible flag and
// pipeline valids, and sets both widths to eight; the inverse memory is
// left as is, and a value read from an unwritten entry is never returned.
// ----------------------------------------------------------------------------
module sbox_inverse_builder
	import sib_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  req_t               req,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output rsp_t               rsp,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	logic [CFG_W-1:0]    in_bits_q;
	logic [CFG_W-1:0]    out_bits_q;
	logic [DEPTH-1:0]    mask_q;
	logic [CNT_W-1:0]    count_q;
	logic                flag_q;

	logic [MAX_BITS-1:0] inv_mem [DEPTH];
	logic [MAX_BITS-1:0] rd_data_s1;
	logic                valid_s1;
	logic                use_mem_s1;
	logic [1:0]          status_s1;

	logic                rsp_valid_q;
	rsp_t                rsp_q;

	logic                accept;
	logic                adv_s1;
	logic                cfg_wr;
	reg_idx_t            cfg_idx;

	logic [CNT_W-1:0]    size;
	logic [CNT_W-1:0]    out_range;
	logic [CNT_W-1:0]    val_ext;
	logic [MAX_BITS-1:0] rd_idx;
	logic                is_load;
	logic                is_read;
	logic                is_restart;
	logic                full;
	logic                bad_val;
	logic                dup_val;
	logic                store_ok;
	logic                flag_next;
	logic [1:0]          status_now;
	logic                use_mem_now;

	// APB access
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = reg_idx_t'(paddr[2]);

	always_comb begin
		prdata = '0;
		case (cfg_idx)
			REG_IN_BITS:  prdata = PDATA_W'(in_bits_q);
			REG_OUT_BITS: prdata = PDATA_W'(out_bits_q);
			default:      prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_bits_q  <= CFG_W'(MAX_BITS);
			out_bits_q <= CFG_W'(MAX_BITS);
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_IN_BITS:  in_bits_q  <= pwdata[CFG_W-1:0];
				REG_OUT_BITS: out_bits_q <= pwdata[CFG_W-1:0];
				default:      ;
			endcase
		end
	end

	// Handshake
	assign adv_s1    = valid_s1 && (!rsp_valid_q || rsp_ready);
	assign req_ready = !valid_s1 || adv_s1;
	assign accept    = req_valid && req_ready;

	// Request decode
	assign is_load    = (req.req_type == REQ_LOAD);
	assign is_read    = (req.req_type == REQ_READ);
	assign is_restart = (req.req_type == REQ_RESTART);
	assign size       = width_to_size(in_bits_q);
	assign out_range  = width_to_size(out_bits_q);
	assign val_ext    = CNT_W'(req.entry_value);
	assign rd_idx     = req.query_index & MAX_BITS'(size - CNT_W'(1));
	assign full       = (count_q >= size);
	assign bad_val    = (val_ext >= out_range) || (val_ext >= size);
	assign dup_val    = mask_q[req.entry_value];
	assign store_ok   = is_load && !full && !bad_val && !dup_val;
	assign flag_next  = flag_q || bad_val || dup_val;

	always_comb begin
		status_now  = ST_OK;
		use_mem_now = 1'b0;
		if (is_load) begin
			if (full)
				status_now = ST_PAST_END;
			else if (flag_next)
				status_now = ST_NOT_INV;
		end else if (is_read) begin
			if ((in_bits_q != out_bits_q) || flag_q)
				status_now = ST_NOT_INV;
			else if ((count_q < size) || !mask_q[rd_idx])
				status_now = ST_INCOMPLETE;
			else
				use_mem_now = 1'b1;
		end
	end

	// Load state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q  <= '0;
			count_q <= '0;
			flag_q  <= 1'b0;
		end else if (accept) begin
			if (is_restart) begin
				mask_q  <= '0;
				count_q <= '0;
				flag_q  <= 1'b0;
			end else if (is_load && !full) begin
				count_q <= count_q + CNT_W'(1);
				flag_q  <= flag_next;
				if (store_ok)
					mask_q[req.entry_value] <= 1'b1;
			end
		end
	end

	// Inverse memory: write on good load, read on read request
	always_ff @(posedge clk) begin
		if (accept && store_ok)
			inv_mem[req.entry_value] <= count_q[MAX_BITS-1:0];
	end

	always_ff @(posedge clk) begin
		if (accept && is_read)
			rd_data_s1 <= inv_mem[rd_idx];
	end

	// Stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (accept)
			valid_s1 <= 1'b1;
		else if (adv_s1)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1  <= status_now;
			use_mem_s1 <= use_mem_now;
		end
	end

	// Response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rsp_valid_q <= 1'b0;
		else if (adv_s1)
			rsp_valid_q <= 1'b1;
		else if (rsp_ready)
			rsp_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			rsp_q.status        <= status_s1;
			rsp_q.inverse_value <= use_mem_s1 ? rd_data_s1 : '0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

@@ rtl/core/sib_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sib_checker
// Port-level checks for the inverse S-box table builder.
// ----------------------------------------------------------------------------
module sib_checker
	import sib_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	input  logic               req_ready,
	input  logic               rsp_valid,
	input  logic               rsp_ready,
	input  rsp_t               rsp,
	input  logic               psel,
	input  logic               penable,
	input  logic               pready
);

	// Hold a stalled response
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	// Drop request ready only behind a stalled response
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!req_ready |-> rsp_valid && !rsp_ready)
		else $error("request stalled without output backpressure");

	// Zero payload on any response that is not a good read
	a_zero_value: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status != ST_OK) |-> rsp.inverse_value == '0)
		else $error("nonzero value on failed response");

	// Advance a taken request through stage 1 into the response register while rsp_ready stays high
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && rsp_ready ##1 rsp_ready |=> rsp_valid)
		else $error("response missing after two cycles");

	// Keep the configuration port always ready
	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable |-> pready)
		else $error("pready low during access");

endmodule

bind sbox_inverse_builder sib_checker u_sib_checker (.*);
